// ===== src/ovl_pkg.sv =====
// ---------------------------------------------------------------------------
// ovl_pkg: shared definitions for the ordered value list
// Sizes, request and status codes, and the per-cell update mode.
// ---------------------------------------------------------------------------
package ovl_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 5;

    // Request codes; codes six and seven are no-ops.
    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_AFTER = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_KEY   = 3'd5;
    localparam logic [FUNC_W-1:0] FN_NOP_A     = 3'd6;
    localparam logic [FUNC_W-1:0] FN_NOP_B     = 3'd7;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NOKEY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        CM_HOLD       = 2'd0,
        CM_LOAD_NEW   = 2'd1,
        CM_TAKE_LEFT  = 2'd2,
        CM_TAKE_RIGHT = 2'd3
    } t_cell_mode;

endpackage

// ===== src/ovl_cell.sv =====
// ---------------------------------------------------------------------------
// ovl_cell: one entry of the ordered value list
// Holds one value, compares it against the search key and loads a new
// value, its left neighbor's or its right neighbor's as commanded.
// ---------------------------------------------------------------------------
module ovl_cell (
    input  logic                        i_clk,
    input  ovl_pkg::t_cell_mode         i_mode,
    input  logic [ovl_pkg::DATA_W-1:0]  i_value,
    input  logic [ovl_pkg::DATA_W-1:0]  i_left,
    input  logic [ovl_pkg::DATA_W-1:0]  i_right,
    input  logic [ovl_pkg::DATA_W-1:0]  i_key,
    output logic [ovl_pkg::DATA_W-1:0]  o_data,
    output logic [ovl_pkg::DATA_W-1:0]  o_next,
    output logic                        o_match
);
    import ovl_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    always_comb begin
        unique case (i_mode)
            CM_LOAD_NEW:   n_data = i_value;
            CM_TAKE_LEFT:  n_data = i_left;
            CM_TAKE_RIGHT: n_data = i_right;
            default:       n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_next  = n_data;
    assign o_match = (r_data == i_key);

endmodule

// ===== src/ordered_value_list.sv =====
// ---------------------------------------------------------------------------
// ordered_value_list: bounded ordered list of signed 32-bit values
// A row of cells, front at cell zero, that inserts at the front, the back, or
// right after the first entry equal to a key, and deletes the front, the back or that entry.
// ---------------------------------------------------------------------------
//
//  Channel   Dir  tdata (low bit up)            tuser
//  s_axis    in   value[31:0], key[63:32]       func[2:0]
//  m_axis    out  front_value[31:0],            status[1:0]
//                 count[36:32], zero pad to 40
//
// For each request every cell compares its value with the key in parallel,
// a ripple chain along the row marks the cells behind the first match, and
// all cells load together at the accepting edge.
// The result sits in an output register; a new request is taken whenever
// that register is empty or being read in the same cycle, so one request a
// cycle is sustained while the consumer keeps up.
// Reset (synchronous, active low) empties the list and the output register.
// Cell contents are not reset; the entry count alone says which cells hold
// entries.
// ---------------------------------------------------------------------------
module ordered_value_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value[31:0], key[63:32]
    input  logic [2:0]  s_axis_tuser,   // func[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // front_value[31:0], count[36:32], pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import ovl_pkg::*;

    // Handshake and request fields.
    logic              w_accept;
    logic [FUNC_W-1:0] w_func;
    logic [DATA_W-1:0] w_value;
    logic [DATA_W-1:0] w_key;

    // List bookkeeping.
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              w_full;
    logic              w_empty;
    logic              w_found;

    // Operation actually carried out this cycle (already qualified).
    logic w_do_ins_front;
    logic w_do_ins_back;
    logic w_do_ins_after;
    logic w_do_del_front;
    logic w_do_del_key;
    t_status w_status;

    // Row of cells.
    t_cell_mode        w_mode  [CAPACITY];
    logic [DATA_W-1:0] w_data  [CAPACITY];
    logic [DATA_W-1:0] w_next  [CAPACITY];
    logic              w_match [CAPACITY];
    logic              w_first [CAPACITY];
    // w_hit[i] is high when a valid entry in cells 0..i-1 equals the key.
    logic              w_hit   [CAPACITY+1];

    // Output register.
    logic              r_m_valid;
    t_status           r_status;
    logic [DATA_W-1:0] r_front;
    logic [CNT_W-1:0]  r_out_count;

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_func        = s_axis_tuser;
    assign w_value       = s_axis_tdata[31:0];
    assign w_key         = s_axis_tdata[63:32];

    assign w_full  = (r_count >= CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    // First-match chain along the row.
    assign w_hit[0] = 1'b0;
    for (genvar g = 0; g < CAPACITY; g++) begin : g_chain
        logic w_valid;
        assign w_valid    = (r_count > CNT_W'(g));
        assign w_first[g] = w_valid && w_match[g] && !w_hit[g];
        assign w_hit[g+1] = w_hit[g] || (w_valid && w_match[g]);
    end
    assign w_found = w_hit[CAPACITY];

    // Request decode: decide status, new count and which operation runs.
    always_comb begin
        w_status       = ST_OK;
        n_count        = r_count;
        w_do_ins_front = 1'b0;
        w_do_ins_back  = 1'b0;
        w_do_ins_after = 1'b0;
        w_do_del_front = 1'b0;
        w_do_del_key   = 1'b0;
        unique case (w_func)
            FN_INS_FRONT, FN_INS_BACK, FN_INS_AFTER: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else if (w_func == FN_INS_FRONT) begin
                    w_do_ins_front = 1'b1;
                    n_count        = r_count + CNT_W'(1);
                end else if (w_func == FN_INS_BACK || w_empty) begin
                    // Insert-after on an empty list just stores the value.
                    w_do_ins_back = 1'b1;
                    n_count       = r_count + CNT_W'(1);
                end else if (!w_found) begin
                    w_status = ST_NOKEY;
                end else begin
                    w_do_ins_after = 1'b1;
                    n_count        = r_count + CNT_W'(1);
                end
            end
            FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_KEY: begin
                if (w_empty) begin
                    w_status = ST_EMPTY;
                end else if (w_func == FN_DEL_FRONT) begin
                    w_do_del_front = 1'b1;
                    n_count        = r_count - CNT_W'(1);
                end else if (w_func == FN_DEL_BACK) begin
                    // The last entry simply falls outside the count.
                    n_count = r_count - CNT_W'(1);
                end else if (!w_found) begin
                    w_status = ST_NOKEY;
                end else begin
                    w_do_del_key = 1'b1;
                    n_count      = r_count - CNT_W'(1);
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Per-cell mode and the cells themselves.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [DATA_W-1:0] w_left;
        logic [DATA_W-1:0] w_right;
        logic              w_shift_r;  // cell takes left neighbor on insert after
        logic              w_load_r;   // cell sits right behind the first match
        logic              w_close;    // cell takes right neighbor on delete key

        if (g == 0) begin : g_head
            assign w_left    = w_data[g];
            assign w_shift_r = 1'b0;
            assign w_load_r  = 1'b0;
        end else begin : g_body
            assign w_left    = w_data[g-1];
            assign w_shift_r = w_hit[g-1];
            assign w_load_r  = w_first[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = w_data[g];
        end else begin : g_mid
            assign w_right = w_data[g+1];
        end

        assign w_close = w_hit[g+1];

        always_comb begin
            w_mode[g] = CM_HOLD;
            if (w_accept) begin
                priority if (w_do_ins_front) begin
                    w_mode[g] = (g == 0) ? CM_LOAD_NEW : CM_TAKE_LEFT;
                end else if (w_do_ins_back) begin
                    w_mode[g] = (r_count == CNT_W'(g)) ? CM_LOAD_NEW : CM_HOLD;
                end else if (w_do_ins_after) begin
                    if (w_load_r) begin
                        w_mode[g] = CM_LOAD_NEW;
                    end else if (w_shift_r) begin
                        w_mode[g] = CM_TAKE_LEFT;
                    end
                end else if (w_do_del_front) begin
                    w_mode[g] = CM_TAKE_RIGHT;
                end else if (w_do_del_key) begin
                    w_mode[g] = w_close ? CM_TAKE_RIGHT : CM_HOLD;
                end else begin
                    // Refused requests, delete back and no-ops leave cells alone.
                    w_mode[g] = CM_HOLD;
                end
            end
        end

        ovl_cell u_cell (
            .i_clk   (i_clk),
            .i_mode  (w_mode[g]),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_key   (w_key),
            .o_data  (w_data[g]),
            .o_next  (w_next[g]),
            .o_match (w_match[g])
        );
    end

    // Count and output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Result payload, taken from the cells' next values.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= w_status;
            r_out_count <= n_count;
            r_front     <= (n_count != '0) ? w_next[0] : '0;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_status;
    assign m_axis_tdata  = {3'b000, COUNT_W'(r_out_count), r_front};

endmodule
